// File: sv/ipid_pkg.sv
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types, constants and microcode for the incremental PID current loop.
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

   // Field widths
   localparam int TargetWidth   = 16;
   localparam int MeasWidth     = 15;
   localparam int GainWidth     = 24;
   localparam int LimitWidth    = 7;
   localparam int PeriodWidth   = 16;
   localparam int PulseWidth    = 16;
   localparam int DutyWidth     = 24;
   localparam int ErrWidth      = 18;
   localparam int DiffWidth     = 20;
   localparam int MagWidth      = 23;
   localparam int ProdWidth     = 48;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;
   localparam int StepWidth     = 4;

   // Register reset values
   localparam logic [GainWidth-1:0]   GainPropReset  = 24'd66;
   localparam logic [GainWidth-1:0]   GainIntReset   = 24'd328;
   localparam logic [GainWidth-1:0]   GainDerivReset = 24'd0;
   localparam logic [LimitWidth-1:0]  DutyLimitReset = 7'd80;
   localparam logic [PeriodWidth-1:0] PwmPeriodReset = 16'd9600;

   // floor(x/100) == (x * RecipHundred) >> RecipShift for x < 2^23
   localparam logic [GainWidth-1:0] RecipHundred = 24'd10737419;
   localparam int RecipShift = 30;

   // Register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_GAIN_P   = 3'd0,
      CSR_GAIN_I   = 3'd1,
      CSR_GAIN_D   = 3'd2,
      CSR_LIMIT    = 3'd3,
      CSR_PERIOD   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GainWidth-1:0]   gain_p;
      logic [GainWidth-1:0]   gain_i;
      logic [GainWidth-1:0]   gain_d;
      logic [LimitWidth-1:0]  duty_limit;
      logic [PeriodWidth-1:0] pwm_period;
   } cfg_type;

   // Microcode fields
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_P,
      MUL_I,
      MUL_D,
      MUL_PERIOD,
      MUL_RECIP
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_IN,
      SEQ_WAIT_OUT
   } seq_op_type;

   typedef logic [StepWidth-1:0] step_type;

   localparam step_type StepIdle   = 4'd0;
   localparam step_type StepMulP   = 4'd1;
   localparam step_type StepMulI   = 4'd2;
   localparam step_type StepMulD   = 4'd3;
   localparam step_type StepAccD   = 4'd4;
   localparam step_type StepCommit = 4'd5;
   localparam step_type StepMulPer = 4'd6;
   localparam step_type StepRecip  = 4'd7;
   localparam step_type StepEmit   = 4'd8;

   typedef struct packed {
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        take_in;
      logic        commit;
      logic        emit;
      seq_op_type  seq_op;
      step_type    jump_to;
   } ctrl_word_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
   } seq_cond_type;

   // Control store
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, take_in: 1'b0, commit: 1'b0,
            emit: 1'b0, seq_op: SEQ_NEXT, jump_to: StepIdle};
      unique case (step)
         StepIdle: begin
            w.take_in = 1'b1;
            w.seq_op  = SEQ_WAIT_IN;
         end
         StepMulP:   w.mul_sel = MUL_P;
         StepMulI: begin
            w.mul_sel = MUL_I;
            w.acc_op  = ACC_LOAD;
         end
         StepMulD: begin
            w.mul_sel = MUL_D;
            w.acc_op  = ACC_ADD;
         end
         StepAccD:   w.acc_op = ACC_ADD;
         StepCommit: w.commit = 1'b1;
         StepMulPer: w.mul_sel = MUL_PERIOD;
         StepRecip:  w.mul_sel = MUL_RECIP;
         StepEmit: begin
            w.emit    = 1'b1;
            w.seq_op  = SEQ_WAIT_OUT;
            w.jump_to = StepIdle;
         end
         default: begin
            w.seq_op  = SEQ_WAIT_OUT;
            w.jump_to = StepIdle;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: sv/ipid_useq.sv
// ----------------------------------------------------------------------------
// ipid_useq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_useq (
   input  wire                    clock,
   input  wire                    reset,
   input  ipid_pkg::seq_cond_type cond,
   output ipid_pkg::ctrl_word_type ctrl
);
   import ipid_pkg::*;

   step_type step_ff;
   step_type step_in;

   always_comb begin
      ctrl = ucode(step_ff);
   end

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.seq_op)
         SEQ_NEXT:     step_in = step_ff + 4'd1;
         SEQ_WAIT_IN:  step_in = cond.in_valid ? step_ff + 4'd1 : step_ff;
         SEQ_WAIT_OUT: step_in = cond.out_free ? ctrl.jump_to : step_ff;
         default:      step_in = StepIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= StepIdle;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/ipid_dpath.sv
// ----------------------------------------------------------------------------
// ipid_dpath
// Error history, shared multiplier, accumulator, clamp and pulse scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_dpath (
   input  wire                                       clock,
   input  wire                                       reset,
   input  ipid_pkg::ctrl_word_type                   ctrl,
   input  wire                                       in_fire,
   input  wire signed [ipid_pkg::TargetWidth-1:0]    target_current,
   input  wire        [ipid_pkg::MeasWidth-1:0]      measured_current,
   input  ipid_pkg::cfg_type                         cfg,
   output logic       [ipid_pkg::PulseWidth-1:0]     pulse_width,
   output logic                                      reverse,
   output logic signed [ipid_pkg::DutyWidth-1:0]     duty_value
);
   import ipid_pkg::*;

   logic signed [ErrWidth-1:0]  err_ff, err_in;
   logic signed [ErrWidth-1:0]  err_last_ff, err_prev_ff;
   logic signed [DutyWidth-1:0] duty_ff, duty_in;
   logic                        dir_ff, dir_in;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic signed [ProdWidth-1:0] acc_ff, acc_in;

   logic signed [ErrWidth-1:0]  meas_signed;
   logic signed [DiffWidth-1:0] diff_p, diff_d;
   logic        [MagWidth-1:0]  duty_mag;
   logic        [GainWidth-1:0] op_a;
   logic signed [GainWidth-1:0] op_b;
   logic signed [ProdWidth:0]   mul_full;
   logic signed [ProdWidth-1:0] limit_pos;
   logic        [ProdWidth-RecipShift-2:0] pw_quot;

   // signed measurement follows the kept direction
   always_comb begin
      meas_signed = dir_ff ? -$signed({3'b000, measured_current})
                           :  $signed({3'b000, measured_current});
      err_in = ErrWidth'(target_current) - meas_signed;
   end

   always_comb begin
      diff_p = DiffWidth'(err_ff) - DiffWidth'(err_last_ff);
      diff_d = DiffWidth'(err_ff) + DiffWidth'(err_prev_ff)
             - (DiffWidth'(err_last_ff) <<< 1);
      duty_mag = duty_ff[DutyWidth-1] ? MagWidth'(-duty_ff) : MagWidth'(duty_ff);
   end

   // operand select for the one shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (ctrl.mul_sel)
         MUL_P: begin
            op_a = cfg.gain_p;
            op_b = GainWidth'(diff_p);
         end
         MUL_I: begin
            op_a = cfg.gain_i;
            op_b = GainWidth'(err_ff);
         end
         MUL_D: begin
            op_a = cfg.gain_d;
            op_b = GainWidth'(diff_d);
         end
         MUL_PERIOD: begin
            op_a = GainWidth'(cfg.pwm_period);
            op_b = $signed({1'b0, duty_mag});
         end
         MUL_RECIP: begin
            op_a = RecipHundred;
            op_b = $signed({1'b0, prod_ff[MagWidth+15:16]});
         end
         default: ;
      endcase
      mul_full = $signed({1'b0, op_a}) * op_b;
      prod_in  = mul_full[ProdWidth-1:0];
   end

   always_comb begin
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = ProdWidth'(duty_ff) + prod_ff;
         ACC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // clamp to +/- limit percent
   always_comb begin
      limit_pos = $signed({{(ProdWidth-LimitWidth-16){1'b0}}, cfg.duty_limit, 16'h0000});
      if (acc_ff > limit_pos) begin
         duty_in = DutyWidth'(limit_pos);
      end else if (acc_ff < -limit_pos) begin
         duty_in = DutyWidth'(-limit_pos);
      end else begin
         duty_in = DutyWidth'(acc_ff);
      end
      dir_in = (duty_in == '0) ? dir_ff : duty_in[DutyWidth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff     <= '0;
         dir_ff      <= 1'b0;
         err_last_ff <= '0;
         err_prev_ff <= '0;
      end else if (ctrl.commit) begin
         duty_ff     <= duty_in;
         dir_ff      <= dir_in;
         err_last_ff <= err_ff;
         err_prev_ff <= err_last_ff;
      end
   end

   // product register holds through steps without a multiply, so the
   // quotient survives a stalled emit step
   always_ff @(posedge clock) begin
      if (in_fire) begin
         err_ff <= err_in;
      end
      if (ctrl.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      acc_ff  <= acc_in;
   end

   // product of the reciprocal step is nonnegative
   always_comb begin
      pw_quot = prod_ff[ProdWidth-2:RecipShift];
      if (duty_ff == '0) begin
         pulse_width = PulseWidth'(1);
      end else if (pw_quot > (ProdWidth-RecipShift-1)'({PulseWidth{1'b1}})) begin
         pulse_width = '1;
      end else begin
         pulse_width = pw_quot[PulseWidth-1:0];
      end
      reverse    = dir_ff;
      duty_value = duty_ff;
   end

endmodule

`default_nettype wire

// File: sv/incremental_pid_current_to_pwm_top.sv
// ----------------------------------------------------------------------------
// incremental_pid_current_to_pwm_top
// Velocity-form PID current loop producing a PWM compare value and direction.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields (lowest bit up)
// -------  ---  ------------------------------------------------------------
// req_     in   target_current[15:0], measured_current[30:16], pad to 32
// rsp_     out  pulse_width[15:0], reverse[16], duty_value[40:17], pad to 48
// csr_     in   wen, index (0 Kp, 1 Ki, 2 Kd, 3 limit, 4 period), wdata[23:0]
//
// One item runs through the nine-step microprogram, which passes five
// products through one 25x24 multiplier, and the program finishes one item
// before it takes the next.
// The next item is accepted as soon as the program is back at its idle
// step, even while the previous result still waits in the output register.
// A stalled result holds the program at its last step.
// Reset (synchronous, active high) clears duty, error history, direction,
// step counter and output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_current_to_pwm_top (
   input  wire                                    clock,
   input  wire                                    reset,
   // item in: target_current[15:0], measured_current[30:16]
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [31:0]                            req_tdata,
   // item out: pulse_width[15:0], reverse[16], duty_value[40:17]
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [47:0]                            rsp_tdata,
   // register writes
   input  wire                                    csr_wen,
   input  wire  [ipid_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire  [ipid_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import ipid_pkg::*;

   cfg_type       cfg_ff;
   ctrl_word_type ctrl;
   seq_cond_type  cond;

   logic in_fire;
   logic out_free;
   logic emit_go;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PulseWidth-1:0] rsp_pw_ff;
   logic                  rsp_rev_ff;
   logic [DutyWidth-1:0]  rsp_duty_ff;

   logic [PulseWidth-1:0]       dp_pulse_width;
   logic                        dp_reverse;
   logic signed [DutyWidth-1:0] dp_duty;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GainPropReset;
         cfg_ff.gain_i     <= GainIntReset;
         cfg_ff.gain_d     <= GainDerivReset;
         cfg_ff.duty_limit <= DutyLimitReset;
         cfg_ff.pwm_period <= PwmPeriodReset;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_GAIN_P: cfg_ff.gain_p     <= csr_wdata;
            CSR_GAIN_I: cfg_ff.gain_i     <= csr_wdata;
            CSR_GAIN_D: cfg_ff.gain_d     <= csr_wdata;
            CSR_LIMIT:  cfg_ff.duty_limit <= csr_wdata[LimitWidth-1:0];
            CSR_PERIOD: cfg_ff.pwm_period <= csr_wdata[PeriodWidth-1:0];
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // handshakes; the output register frees up when its item is taken
   always_comb begin
      req_tready    = ctrl.take_in;
      in_fire       = req_tvalid && ctrl.take_in;
      out_free      = !rsp_valid_ff || rsp_tready;
      emit_go       = ctrl.emit && out_free;
      cond.in_valid = req_tvalid;
      cond.out_free = out_free;
   end

   ipid_useq u_useq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   ipid_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .in_fire          (in_fire),
      .target_current   (req_tdata[TargetWidth-1:0]),
      .measured_current (req_tdata[TargetWidth+MeasWidth-1:TargetWidth]),
      .cfg              (cfg_ff),
      .pulse_width      (dp_pulse_width),
      .reverse          (dp_reverse),
      .duty_value       (dp_duty)
   );

   // output register
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_pw_ff   <= dp_pulse_width;
         rsp_rev_ff  <= dp_reverse;
         rsp_duty_ff <= dp_duty;
      end
   end

   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {7'b0000000, rsp_duty_ff, rsp_rev_ff, rsp_pw_ff};
   end

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------

   // program leaves idle right after taking an item
   a_one_item_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");

   // zero duty gives a pulse width of one
   a_zero_duty_pulse : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_duty_ff == '0) |-> (rsp_pw_ff == PulseWidth'(1)))
      else $error("zero duty without unit pulse");

   // direction follows the sign of a nonzero duty
   a_dir_matches_sign : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_duty_ff != '0) |-> (rsp_rev_ff == rsp_duty_ff[DutyWidth-1]))
      else $error("direction disagrees with duty sign");

endmodule

`default_nettype wire
